// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the ready queue.
// Self-contained; included by priority_ready_queue_unit to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define PRQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the standard clk_i / rst_ni pair.
`define PRQ_ASSERT(lbl, prop, msg) \
  `PRQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/prq_pkg.sv =====
// Package for the priority ready queue: field widths, opcodes, result struct.
// No dependencies; imported by every module of the block.
package prq_pkg;

  localparam int DEF_QUEUE_DEPTH     = 64;
  localparam int DEF_PRIORITY_LEVELS = 64;

  localparam int ID_W        = 8;
  localparam int PRIO_W      = 6;
  localparam int OCC_W       = 7;
  localparam int ENTRY_W     = ID_W + PRIO_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic              popped_valid;
    logic [ID_W-1:0]   popped_id;
    logic [PRIO_W-1:0] popped_priority;
    logic              idle_selected;
    logic              overflow;
    logic              preempt;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

endpackage

// ===== sv/priority_ready_queue_unit.sv =====
// Top level of the priority ready queue: stream ports, result register,
// entry store and sequencer. Depends on prq_pkg, prq_ram, prq_seq and assert_macros.svh.
//
//  channel  | dir | handshake                | contents
//  s_axis   | in  | s_axis_tvalid_i/tready_o | insert or pop request
//  m_axis   | out | m_axis_tvalid_o/tready_i | one result per request
//
// A pop passes through S_POP, S_HRD and S_HCHK (an empty queue skips S_POP), an insert
// into a full queue goes to S_HRD and S_HCHK, and any other insert first walks S_WALK and
// S_CMP past the stored entries of lower priority (up to QUEUE_DEPTH - 1): one read port
// moves one entry a cycle. s_axis_tready_o is low while a request is being worked on; the
// result register lets the next request in while the previous result waits.
// Reset empties the queue at once; the store itself is not cleared.
module priority_ready_queue_unit import prq_pkg::*; #(
  parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [7:0] task_id, [13:8] task_priority, [19:14] current_priority, [23:20] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] opcode
  input  logic                   s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [0] popped_valid, [8:1] popped_id, [14:9] popped_priority, [15] idle_selected,
  // [16] overflow, [17] preempt, [24:18] occupancy, [31:25] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  `include "assert_macros.svh"

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic               seq_idle, start, out_free, res_valid;
  result_t            res, res_q;
  logic               out_valid_q, out_valid_d;
  logic               mem_we, mem_re;
  logic [PTR_W-1:0]   mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  logic               pop_both_kinds, overflow_on_pop;

  assign s_axis_tready_o = seq_idle;
  assign start           = s_axis_tvalid_i && seq_idle;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  prq_seq #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .opcode_i           (s_axis_tuser_i),
    .task_id_i          (s_axis_tdata_i[7:0]),
    .task_priority_i    (s_axis_tdata_i[13:8]),
    .current_priority_i (s_axis_tdata_i[19:14]),
    .idle_o             (seq_idle),
    .out_free_i         (out_free),
    .res_valid_o        (res_valid),
    .res_o              (res),
    .mem_we_o           (mem_we),
    .mem_waddr_o        (mem_waddr),
    .mem_wdata_o        (mem_wdata),
    .mem_re_o           (mem_re),
    .mem_raddr_o        (mem_raddr),
    .mem_rdata_i        (mem_rdata)
  );

  prq_ram #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, res_q.occupancy, res_q.preempt, res_q.overflow,
                            res_q.idle_selected, res_q.popped_priority,
                            res_q.popped_id, res_q.popped_valid};

  assign pop_both_kinds  = res_q.popped_valid && res_q.idle_selected;
  assign overflow_on_pop = res_q.overflow && (res_q.popped_valid || res_q.idle_selected);

  `PRQ_ASSERT(a_busy_after_accept, start |=> !s_axis_tready_o, "accepted a request while busy")
  `PRQ_ASSERT(a_no_result_overwrite, res_valid |-> out_free, "result overwritten before transfer")
  `PRQ_ASSERT(a_pop_kind_exclusive, m_axis_tvalid_o |-> !pop_both_kinds, "pop removed and idle")
  `PRQ_ASSERT(a_overflow_not_pop, m_axis_tvalid_o |-> !overflow_on_pop, "overflow on a pop result")

endmodule

// ===== sv/prq_ram.sv =====
// Single-port-write, single-port-read entry store with registered read data.
// Depends on prq_pkg for the entry width.
module prq_ram import prq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [PTR_W-1:0]   waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [PTR_W-1:0]   raddr_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/prq_seq.sv =====
// Sequencer of the ready queue: circular buffer pointers, insertion walk
// with one shared priority compare, pop and head check. Uses prq_pkg.
module prq_seq import prq_pkg::*; #(
  parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
  localparam int PTR_W          = $clog2(QUEUE_DEPTH),
  localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               opcode_i,
  input  logic [ID_W-1:0]    task_id_i,
  input  logic [PRIO_W-1:0]  task_priority_i,
  input  logic [PRIO_W-1:0]  current_priority_i,
  output logic               idle_o,
  input  logic               out_free_i,
  output logic               res_valid_o,
  output result_t            res_o,
  output logic               mem_we_o,
  output logic [PTR_W-1:0]   mem_waddr_o,
  output logic [ENTRY_W-1:0] mem_wdata_o,
  output logic               mem_re_o,
  output logic [PTR_W-1:0]   mem_raddr_o,
  input  logic [ENTRY_W-1:0] mem_rdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_HRD  = 3'd4;
  localparam logic [2:0] S_HCHK = 3'd5;

  localparam int PRIO_MAX_I = (PRIORITY_LEVELS - 1 > 63) ? 63 : PRIORITY_LEVELS - 1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(PRIO_MAX_I);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
    return (p > PRIO_MAX) ? PRIO_MAX : p;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

  logic [2:0]        state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d, wa_q, wa_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, k_q, k_d;
  logic [ID_W-1:0]   new_id_q, new_id_d, pid_q, pid_d;
  logic [PRIO_W-1:0] new_prio_q, new_prio_d, cur_q, cur_d, ppr_q, ppr_d;
  logic              pv_q, pv_d, idle_sel_q, idle_sel_d, ovf_q, ovf_d;

  logic [ID_W-1:0]   rd_id;
  logic [PRIO_W-1:0] rd_prio;
  logic              stop_here;

  assign rd_id   = mem_rdata_i[ENTRY_W-1:PRIO_W];
  assign rd_prio = mem_rdata_i[PRIO_W-1:0];
  // shared compare: new entry goes after any stored entry of equal or higher priority
  assign stop_here = (rd_prio >= new_prio_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    wa_d       = wa_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    new_id_d   = new_id_q;
    new_prio_d = new_prio_q;
    cur_d      = cur_q;
    pv_d       = pv_q;
    pid_d      = pid_q;
    ppr_d      = ppr_q;
    idle_sel_d = idle_sel_q;
    ovf_d      = ovf_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wa_q;
    mem_wdata_o = {new_id_q, new_prio_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          new_id_d   = task_id_i;
          new_prio_d = clamp_prio(task_priority_i);
          cur_d      = clamp_prio(current_priority_i);
          pv_d       = 1'b0;
          pid_d      = '0;
          ppr_d      = '0;
          idle_sel_d = 1'b0;
          ovf_d      = 1'b0;
          if (opcode_i == OP_POP) begin
            if (cnt_q == '0) begin
              idle_sel_d = 1'b1;
              state_d    = S_HRD;
            end else begin
              mem_re_o = 1'b1;
              state_d  = S_POP;
            end
          end else begin
            if (cnt_q == CNT_FULL) begin
              ovf_d   = 1'b1;
              state_d = S_HRD;
            end else begin
              wa_d    = tail_q;
              k_d     = cnt_q;
              state_d = S_WALK;
            end
          end
        end
      end
      S_POP: begin
        pv_d    = 1'b1;
        pid_d   = rd_id;
        ppr_d   = rd_prio;
        head_d  = ptr_inc(head_q);
        cnt_d   = cnt_q - CNT_W'(1);
        state_d = S_HRD;
      end
      S_WALK: begin
        if (k_q == '0) begin
          mem_we_o = 1'b1;
          tail_d   = ptr_inc(tail_q);
          cnt_d    = cnt_q + CNT_W'(1);
          state_d  = S_HRD;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_dec(wa_q);
          state_d     = S_CMP;
        end
      end
      S_CMP: begin
        mem_we_o = 1'b1;
        if (stop_here) begin
          tail_d  = ptr_inc(tail_q);
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_HRD;
        end else begin
          // move the lower-priority entry one slot toward the tail
          mem_wdata_o = mem_rdata_i;
          wa_d        = ptr_dec(wa_q);
          k_d         = k_q - CNT_W'(1);
          if (k_q == CNT_W'(1)) begin
            state_d = S_WALK;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = ptr_dec(ptr_dec(wa_q));
          end
        end
      end
      S_HRD: begin
        mem_re_o = 1'b1;
        state_d  = S_HCHK;
      end
      S_HCHK: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_o.popped_valid    = pv_q;
    res_o.popped_id       = pid_q;
    res_o.popped_priority = ppr_q;
    res_o.idle_selected   = idle_sel_q;
    res_o.overflow        = ovf_q;
    res_o.preempt         = (cnt_q != '0) && (rd_prio > cur_q);
    res_o.occupancy       = OCC_W'(cnt_q);
  end

  assign idle_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q       <= wa_d;
    k_q        <= k_d;
    new_id_q   <= new_id_d;
    new_prio_q <= new_prio_d;
    cur_q      <= cur_d;
    pv_q       <= pv_d;
    pid_q      <= pid_d;
    ppr_q      <= ppr_d;
    idle_sel_q <= idle_sel_d;
    ovf_q      <= ovf_d;
  end

endmodule

// ===== tb/prq_checker.sv =====
// Scoreboard for priority_ready_queue_unit: watches both stream channels,
// keeps its own copy of the sorted ready queue and compares every result.
// Depends on prq_pkg.
module prq_checker import prq_pkg::*; #(
  parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tuser_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ID_W-1:0]   ready_id   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] ready_prio [QUEUE_DEPTH];
  int                ready_count;
  result_t           awaited_results [$];
  int                errors;

  function automatic logic [PRIO_W-1:0] saturate_prio(input logic [PRIO_W-1:0] p);
    if (int'(p) > PRIORITY_LEVELS - 1) begin
      return PRIO_W'(PRIORITY_LEVELS - 1);
    end
    return p;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  // Apply one request to the ready queue and queue up the result it must produce.
  task automatic schedule_request(input logic op, input logic [IN_TDATA_W-1:0] data);
    result_t           r;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] cur;
    int                pos;
    r    = '0;
    id   = data[ID_W-1:0];
    prio = saturate_prio(data[ID_W +: PRIO_W]);
    cur  = saturate_prio(data[ID_W+PRIO_W +: PRIO_W]);
    if (op == OP_INSERT) begin
      if (ready_count >= QUEUE_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < ready_count && ready_prio[pos] >= prio) pos++;
        for (int i = ready_count; i > pos; i--) begin
          ready_id[i]   = ready_id[i-1];
          ready_prio[i] = ready_prio[i-1];
        end
        ready_id[pos]   = id;
        ready_prio[pos] = prio;
        ready_count++;
      end
    end else if (ready_count == 0) begin
      r.idle_selected = 1'b1;
    end else begin
      r.popped_valid    = 1'b1;
      r.popped_id       = ready_id[0];
      r.popped_priority = ready_prio[0];
      for (int i = 1; i < ready_count; i++) begin
        ready_id[i-1]   = ready_id[i];
        ready_prio[i-1] = ready_prio[i];
      end
      ready_count--;
    end
    r.preempt   = (ready_count > 0) && (ready_prio[0] > cur);
    r.occupancy = OCC_W'(ready_count);
    awaited_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [OUT_TDATA_W-1:0] d;
    result_t                want;
    if (!rst_ni) begin
      ready_count = 0;
      errors      = 0;
      awaited_results.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        schedule_request(s_axis_tuser_i, s_axis_tdata_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        d = m_axis_tdata_i;
        if (awaited_results.size() == 0) begin
          report_error($sformatf("result transfer 0x%h with none outstanding", d));
        end else begin
          want = awaited_results.pop_front();
          check_field("popped_valid", int'(d[0]), int'(want.popped_valid));
          check_field("popped_id", int'(d[8:1]), int'(want.popped_id));
          check_field("popped_priority", int'(d[14:9]), int'(want.popped_priority));
          check_field("idle_selected", int'(d[15]), int'(want.idle_selected));
          check_field("overflow", int'(d[16]), int'(want.overflow));
          check_field("preempt", int'(d[17]), int'(want.preempt));
          check_field("occupancy", int'(d[24:18]), int'(want.occupancy));
          check_field("padding", int'(d[31:25]), 0);
        end
      end
    end
    fail_count_o <= errors;
    pending_o    <= awaited_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the ready queue testbench: clock, reset, request and result traffic,
// verdict. Depends on prq_pkg, priority_ready_queue_unit and prq_checker.
module testbench;
  import prq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  int                     fail_count;
  int                     pending;
  bit                     no_gaps;

  priority_ready_queue_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  prq_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  task automatic send_request(input logic op, input logic [ID_W-1:0] id,
                              input logic [PRIO_W-1:0] prio, input logic [PRIO_W-1:0] cur);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= IN_TDATA_W'({cur, prio, id});
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // hold requests back until every outstanding result has been taken
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 6'd63 : 6'd0;
      1:       return PRIO_W'($urandom_range(28, 35));  // narrow band, lots of ties
      default: return PRIO_W'($urandom_range(0, 63));
    endcase
  endfunction

  // result side: random stall before each transfer, none while no_gaps is set
  initial begin : result_sink
    int stall;
    m_axis_tready_i <= 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin : stimulus
    int insert_pct [4];
    logic op;
    insert_pct = '{95, 10, 50, 90};
    no_gaps = 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tuser_i  <= OP_INSERT;
    s_axis_tdata_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pops, extremes, equal-priority ordering, preempt edges
    send_request(OP_POP, 8'h00, 6'd0, 6'd0);
    send_request(OP_POP, 8'hFF, 6'd63, 6'd63);
    send_request(OP_INSERT, 8'h00, 6'd0, 6'd0);
    send_request(OP_INSERT, 8'hFF, 6'd63, 6'd62);
    send_request(OP_INSERT, 8'h5A, 6'd63, 6'd63);
    send_request(OP_INSERT, 8'hA5, 6'd0, 6'd0);
    send_request(OP_INSERT, 8'h3C, 6'd32, 6'd31);
    send_request(OP_INSERT, 8'hC3, 6'd32, 6'd32);
    send_request(OP_INSERT, 8'h81, 6'd21, 6'd42);
    send_request(OP_POP, 8'h00, 6'd0, 6'd0);
    send_request(OP_POP, 8'hFF, 6'd63, 6'd63);
    send_request(OP_POP, 8'h00, 6'd0, 6'd32);
    send_request(OP_POP, 8'h00, 6'd0, 6'd31);
    send_request(OP_POP, 8'h00, 6'd0, 6'd20);
    send_request(OP_POP, 8'h00, 6'd0, 6'd0);
    send_request(OP_POP, 8'h00, 6'd0, 6'd63);
    send_request(OP_POP, 8'h00, 6'd0, 6'd0);
    wait_drained();

    // fill to overflow, drain to idle, mix, fill again
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 100; n++) begin
        if (n % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        if (ph == 2 && n == 50) wait_drained();
        op = ($urandom_range(0, 99) < insert_pct[ph]) ? OP_INSERT : OP_POP;
        send_request(op, ID_W'($urandom_range(0, 255)), pick_prio(),
                     ($urandom_range(0, 4) == 0) ? pick_prio()
                                                 : PRIO_W'($urandom_range(0, 63)));
      end
      wait_drained();
    end

    no_gaps = 1'b0;
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** priority_ready_queue_unit: PASSED **");
    end else begin
      $display("** priority_ready_queue_unit: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("** priority_ready_queue_unit: FAILED **");
    $finish;
  end

endmodule
